>>> hw/rtl/radius_vertex_weld_table_top_macros.svh
// Assertion macros for the vertex weld table; clocked on clk_i, reset rst_ni.
`ifndef RADIUS_VERTEX_WELD_TABLE_TOP_MACROS_SVH
`define RADIUS_VERTEX_WELD_TABLE_TOP_MACROS_SVH

// Same-cycle implication.
`define RVWT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RVWT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rvwt_pkg.sv
// ---------------------------------------------------------------------------
// rvwt_pkg
// Shared constants, codes and types of the radius vertex weld table.
// ---------------------------------------------------------------------------
`default_nettype none

package rvwt_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int COORD_W_DEF  = 32;
  localparam int ID_W         = 32;
  localparam int RADIUS_W     = 32;
  localparam int MUL_W        = 32;
  localparam int CFG_IDX_W    = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_METRIC = 1'b1;

  // Actions
  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_FIND = 2'd1;
  localparam logic [1:0] ACT_LIST = 2'd2;
  localparam logic [1:0] ACT_WELD = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_MATCH  = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_ADDED  = 2'd2;
  localparam logic [1:0] ST_REJECT = 2'd3;

  localparam logic [ID_W-1:0] ID_EXHAUSTED = '1;

  // Multiplier operand select
  typedef enum logic [1:0] {
    MUL_RR,
    MUL_DX,
    MUL_DY,
    MUL_DZ
  } mul_sel_e;

  typedef struct packed {
    logic     load_diff;
    logic     mul_en;
    mul_sel_e sel;
  } dist_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/radius_vertex_weld_table_top.sv
// ---------------------------------------------------------------------------
// radius_vertex_weld_table_top
// Point table with add, find, list and weld requests over a radius test.
// ---------------------------------------------------------------------------
//  channel | handshake               | payload
//  in      | in_valid_i / in_ready_o | action, item_index, pos_x, pos_y, pos_z
//  out     | out_valid_o/ out_ready_i| index_out, status, last
//  cfg     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// Add goes through S_ADD and then offers its word in S_OUT. Find, list and
// weld scan the table in passes of S_RSQ, then per stored entry S_RD, S_DIFF,
// S_SQX, S_SQY, S_SQZ and S_EVAL (box metric skips the squaring states), then
// S_DONE, set by the single shared multiplier and the one RAM read port. List
// runs one pass per reported id. No clearing pass after reset: the entry
// count guards all reads. Input is refused from acceptance until the final
// word of the run is taken; a stalled output word holds the sequencer.
`default_nettype none

module radius_vertex_weld_table_top #(
  parameter int CAPACITY    = rvwt_pkg::CAPACITY_DEF,
  parameter int COORD_WIDTH = rvwt_pkg::COORD_W_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [rvwt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rvwt_pkg::RADIUS_W-1:0]   cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [1:0]                      action_i,
  input  wire logic [rvwt_pkg::ID_W-1:0]       item_index_i,
  input  wire logic [31:0]                     pos_x_i,
  input  wire logic [31:0]                     pos_y_i,
  input  wire logic [31:0]                     pos_z_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [rvwt_pkg::ID_W-1:0]            index_out_o,
  output logic [1:0]                           status_o,
  output logic                                 last_o
);
  import rvwt_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int WORD_W = ID_W + 3 * CW;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_RSQ, S_RD, S_DIFF, S_SQX, S_SQY, S_SQZ, S_EVAL, S_DONE, S_OUT
  } state_e;

  state_e            state_q;
  logic [RADIUS_W-1:0] radius_q;
  logic              metric_q;
  logic [CNT_W-1:0]  count_q;
  logic [ID_W-1:0]   next_id_q;
  logic [1:0]        act_q;
  logic [ID_W-1:0]   id_q;
  logic [CW-1:0]     px_q, py_q, pz_q;
  logic [CNT_W-1:0]  k_q;
  logic              use_floor_q;
  logic [ID_W-1:0]   floor_q;
  logic              f1_q, f2_q;
  logic [ID_W-1:0]   b1_q, b2_q;
  logic              more_q;

  logic              full;
  logic              weld_new;
  logic              ram_we;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;
  logic [ID_W-1:0]   eid;
  logic              near;
  logic              cand;
  dist_ctrl_t        dctrl;

  assign full     = count_q >= CAP;
  assign weld_new = (act_q == ACT_WELD) && !f1_q && !full && (next_id_q != ID_EXHAUSTED);
  assign ram_we   = ((state_q == S_ADD) && !full) || ((state_q == S_DONE) && weld_new);
  assign ram_wdata = {(state_q == S_ADD) ? id_q : next_id_q, px_q, py_q, pz_q};
  assign eid      = ram_rdata[WORD_W-1 -: ID_W];
  assign cand     = near && (!use_floor_q || (eid > floor_q));
  assign in_ready_o = (state_q == S_IDLE);

  // Drive the distance unit
  always_comb begin
    dctrl.load_diff = (state_q == S_DIFF);
    dctrl.mul_en    = 1'b1;
    unique case (state_q)
      S_RSQ:   dctrl.sel = MUL_RR;
      S_SQX:   dctrl.sel = MUL_DX;
      S_SQY:   dctrl.sel = MUL_DY;
      S_SQZ:   dctrl.sel = MUL_DZ;
      default: begin
        dctrl.sel    = MUL_DX;
        dctrl.mul_en = 1'b0;
      end
    endcase
  end

  rvwt_ram #(
    .WIDTH  (WORD_W),
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (k_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  rvwt_dist #(
    .COORD_WIDTH (CW)
  ) u_dist (
    .clk_i    (clk_i),
    .ctrl_i   (dctrl),
    .ex_i     (ram_rdata[3*CW-1 -: CW]),
    .ey_i     (ram_rdata[2*CW-1 -: CW]),
    .ez_i     (ram_rdata[CW-1:0]),
    .px_i     (px_q),
    .py_i     (py_q),
    .pz_i     (pz_q),
    .radius_i (radius_q),
    .metric_i (metric_q),
    .near_o   (near)
  );

  // Sequencer, configuration and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      radius_q    <= RADIUS_W'(65536);
      metric_q    <= 1'b0;
      count_q     <= '0;
      next_id_q   <= '0;
      out_valid_o <= 1'b0;
      use_floor_q <= 1'b0;
      f1_q        <= 1'b0;
      f2_q        <= 1'b0;
      more_q      <= 1'b0;
      k_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_RADIUS: radius_q <= cfg_wdata_i;
          default:    metric_q <= cfg_wdata_i[0];
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q       <= action_i;
            id_q        <= item_index_i;
            px_q        <= pos_x_i[CW-1:0];
            py_q        <= pos_y_i[CW-1:0];
            pz_q        <= pos_z_i[CW-1:0];
            use_floor_q <= 1'b0;
            f1_q        <= 1'b0;
            f2_q        <= 1'b0;
            k_q         <= '0;
            if (radius_q == '0) begin
              index_out_o <= '0;
              status_o    <= ST_REJECT;
              last_o      <= 1'b1;
              more_q      <= 1'b0;
              out_valid_o <= 1'b1;
              state_q     <= S_OUT;
            end else if (action_i == ACT_ADD) begin
              state_q <= S_ADD;
            end else begin
              state_q <= S_RSQ;
            end
          end
        end
        S_ADD: begin
          index_out_o <= full ? '0 : id_q;
          status_o    <= full ? ST_REJECT : ST_ADDED;
          last_o      <= 1'b1;
          more_q      <= 1'b0;
          out_valid_o <= 1'b1;
          if (!full) begin
            count_q <= count_q + 1'b1;
          end
          state_q <= S_OUT;
        end
        S_RSQ: begin
          state_q <= (count_q == '0) ? S_DONE : S_RD;
        end
        S_RD: begin
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          state_q <= metric_q ? S_EVAL : S_SQX;
        end
        S_SQX: state_q <= S_SQY;
        S_SQY: state_q <= S_SQZ;
        S_SQZ: state_q <= S_EVAL;
        S_EVAL: begin
          // Keep the two lowest distinct ids above the floor
          if (cand) begin
            if (!f1_q || (eid < b1_q)) begin
              b2_q <= b1_q;
              f2_q <= f1_q;
              b1_q <= eid;
              f1_q <= 1'b1;
            end else if ((eid != b1_q) && (!f2_q || (eid < b2_q))) begin
              b2_q <= eid;
              f2_q <= 1'b1;
            end
          end
          if (k_q + 1'b1 == count_q) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          last_o      <= 1'b1;
          more_q      <= 1'b0;
          out_valid_o <= 1'b1;
          state_q     <= S_OUT;
          if (f1_q) begin
            index_out_o <= b1_q;
            status_o    <= ST_MATCH;
            if ((act_q == ACT_LIST) && f2_q) begin
              last_o <= 1'b0;
              more_q <= 1'b1;
            end
          end else if (act_q != ACT_WELD) begin
            index_out_o <= '0;
            status_o    <= ST_NONE;
          end else if (weld_new) begin
            index_out_o <= next_id_q;
            status_o    <= ST_ADDED;
            next_id_q   <= next_id_q + 1'b1;
            count_q     <= count_q + 1'b1;
          end else begin
            index_out_o <= '0;
            status_o    <= ST_REJECT;
          end
        end
        S_OUT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            if (more_q) begin
              // Next pass reports ids above the one just taken
              floor_q     <= b1_q;
              use_floor_q <= 1'b1;
              f1_q        <= 1'b0;
              f2_q        <= 1'b0;
              k_q         <= '0;
              state_q     <= S_RSQ;
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "radius_vertex_weld_table_top_macros.svh"

  `RVWT_ASSERT_IMPL(a_no_overlap, in_ready_o, !out_valid_o, "input taken while word pending")
  `RVWT_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CAP, "entry count above capacity")
  `RVWT_ASSERT_NEXT(a_run_end, out_valid_o && out_ready_i, in_ready_o == $past(last_o), "run end mismatch")
  `RVWT_ASSERT_IMPL(a_zero_id, out_valid_o && (status_o == ST_NONE || status_o == ST_REJECT), index_out_o == '0, "nonzero id without match")

endmodule

`default_nettype wire

>>> hw/rtl/rvwt_ram.sv
// ---------------------------------------------------------------------------
// rvwt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module rvwt_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

>>> hw/rtl/rvwt_dist.sv
// ---------------------------------------------------------------------------
// rvwt_dist
// Shared distance unit: absolute differences, one multiplier with an
// accumulator for the squared distance, and the radius test.
// ---------------------------------------------------------------------------
`default_nettype none

module rvwt_dist #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic                           clk_i,
  input  wire rvwt_pkg::dist_ctrl_t           ctrl_i,
  input  wire logic [COORD_WIDTH-1:0]         ex_i,
  input  wire logic [COORD_WIDTH-1:0]         ey_i,
  input  wire logic [COORD_WIDTH-1:0]         ez_i,
  input  wire logic [COORD_WIDTH-1:0]         px_i,
  input  wire logic [COORD_WIDTH-1:0]         py_i,
  input  wire logic [COORD_WIDTH-1:0]         pz_i,
  input  wire logic [rvwt_pkg::RADIUS_W-1:0]  radius_i,
  input  wire logic                           metric_i,
  output logic                                near_o
);
  import rvwt_pkg::*;

  localparam int CW = COORD_WIDTH;

  logic [CW-1:0]      dx_q, dy_q, dz_q;
  logic [CW-1:0]      dx_d, dy_d, dz_d;
  logic [MUL_W-1:0]   op;
  logic [2*MUL_W-1:0] prod;
  logic [2*MUL_W-1:0] rr_q;
  logic [2*MUL_W+1:0] acc_q;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic signed [CW:0] d;
    logic        [CW:0] m;
    d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
    m = d[CW] ? (~d + 1'b1) : d;
    return m[CW-1:0];
  endfunction

  assign dx_d = abs_diff(ex_i, px_i);
  assign dy_d = abs_diff(ey_i, py_i);
  assign dz_d = abs_diff(ez_i, pz_i);

  // Pick the multiplier operand
  always_comb begin
    case (ctrl_i.sel)
      MUL_RR:  op = radius_i;
      MUL_DX:  op = MUL_W'(dx_q);
      MUL_DY:  op = MUL_W'(dy_q);
      default: op = MUL_W'(dz_q);
    endcase
  end

  assign prod = op * op;

  // Hold differences, square and accumulate
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_diff) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      dz_q <= dz_d;
    end
    if (ctrl_i.mul_en) begin
      case (ctrl_i.sel)
        MUL_RR:  rr_q  <= prod;
        MUL_DX:  acc_q <= {2'b00, prod};
        default: acc_q <= acc_q + {2'b00, prod};
      endcase
    end
  end

  // Radius test, boundary included
  always_comb begin
    if (metric_i) begin
      near_o = (MUL_W'(dx_q) <= radius_i) && (MUL_W'(dy_q) <= radius_i)
            && (MUL_W'(dz_q) <= radius_i);
    end else begin
      near_o = acc_q <= {2'b00, rr_q};
    end
  end

endmodule

`default_nettype wire
